FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked at the same edge as the antecedent.
`define GBTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked at the edge after the antecedent.
`define GBTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gbts_pkg.sv
package gbts_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int CHAR_W       = 8;
    localparam int POS_W        = 11;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_BACKSPACE = 3'd1,
        OP_LEFT      = 3'd2,
        OP_RIGHT     = 3'd3,
        OP_MOVE_TO   = 3'd4,
        OP_DELETE    = 3'd5,
        OP_READ      = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DEL,
        S_RDWAIT
    } t_state;

endpackage

FILE: rtl/gbts_if.sv
interface gbts_cmd_if;
    import gbts_pkg::*;

    logic              valid;
    logic              ready;
    t_op               op;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  range_end;

    modport source (output valid, op, char_in, position, range_end, input ready);
    modport sink   (input valid, op, char_in, position, range_end, output ready);
endinterface

interface gbts_rsp_if;
    import gbts_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    t_status           status;
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  text_length;

    modport source (output valid, char_out, status, cursor, text_length, input ready);
    modport sink   (input valid, char_out, status, cursor, text_length, output ready);
endinterface

FILE: rtl/gbts_ram.sv
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: rtl/gap_buffer_text_store.sv
// Insert, backspace, clear and a rejected left, right, delete or read finish in the execute state;
// read passes through a read-wait state; left, right and move_to walk the gap over d bytes (d
// is 1 for left and right), and delete walks and then drops the range in a delete state.
// One command at a time: the next is taken at the earliest while the previous result beat
// is shown, and a stalled beat holds input off.
// Reset empties the text (cursor 0, gap up to capacity); store contents are kept.
module gap_buffer_text_store #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbts_cmd_if.sink  i_cmd,
    gbts_rsp_if.source o_rsp
);
    import gbts_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (PW > POS_W) ? PW : POS_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    t_state            r_state, n_state;
    logic [PW-1:0]     r_gs, n_gs, r_ge, n_ge, r_tgt, n_tgt;
    t_op               r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [POS_W-1:0]  r_pos, r_rend;
    t_status           r_stat, n_stat;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_waddr, n_waddr;

    logic              r_ov;
    logic [CHAR_W-1:0] r_char_out, n_rd;
    t_status           r_status;
    logic [POS_W-1:0]  r_cursor, r_len;

    logic              w_fin, w_accept;
    logic              w_we, w_re;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [CHAR_W-1:0] w_wdata, w_rdata;

    logic [PW-1:0]     w_len, w_gs_dec, w_ge_dec, w_gs_inc, w_ge_inc, n_len;
    logic [CW-1:0]     w_pos_x, w_len_x, w_gs_x, w_rd_phys, w_cnt_x, w_room_x, w_adv;
    logic              w_full, w_gs_zero, w_ge_top, w_pos_gt_len, w_del_bad;
    logic              w_rd_bad, w_at_tgt;

    gbts_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_ov || o_rsp.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign o_rsp.valid       = r_ov;
    assign o_rsp.char_out    = r_char_out;
    assign o_rsp.status      = r_status;
    assign o_rsp.cursor      = r_cursor;
    assign o_rsp.text_length = r_len;

    assign w_len     = CAP_P - (r_ge - r_gs);
    assign w_gs_dec  = r_gs - 1'b1;
    assign w_ge_dec  = r_ge - 1'b1;
    assign w_gs_inc  = r_gs + 1'b1;
    assign w_ge_inc  = r_ge + 1'b1;
    assign w_pos_x   = CW'(r_pos);
    assign w_len_x   = CW'(w_len);
    assign w_gs_x    = CW'(r_gs);
    assign w_full    = (r_gs == r_ge);
    assign w_gs_zero = (r_gs == '0);
    assign w_ge_top  = (r_ge == CAP_P);
    assign w_at_tgt  = (r_gs == r_tgt);
    assign w_pos_gt_len = (w_pos_x > w_len_x);
    assign w_del_bad    = (r_pos >= r_rend) || w_pos_gt_len;
    assign w_rd_bad     = (w_pos_x >= w_len_x);

    // A read behind the cursor hits the front part; otherwise it skips the gap.
    assign w_rd_phys = (w_pos_x < w_gs_x) ? w_pos_x : w_pos_x + CW'(r_ge - r_gs);

    // The delete range is cut where the text after the cursor ends.
    assign w_cnt_x  = CW'(r_rend - r_pos);
    assign w_room_x = CW'(CAP_P - r_ge);
    assign w_adv    = (w_cnt_x < w_room_x) ? w_cnt_x : w_room_x;

    assign n_len = CAP_P - (n_ge - n_gs);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_LEFT:    n_state = w_gs_zero ? S_IDLE : S_WALK;
                    OP_RIGHT:   n_state = w_ge_top ? S_IDLE : S_WALK;
                    OP_MOVE_TO: n_state = S_WALK;
                    OP_DELETE:  n_state = w_del_bad ? S_IDLE : S_WALK;
                    OP_READ:    n_state = w_rd_bad ? S_IDLE : S_RDWAIT;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_WALK: begin
                if (w_at_tgt) begin
                    n_state = (r_op == OP_DELETE) ? S_DEL : S_IDLE;
                end
            end
            S_DEL:    n_state = S_IDLE;
            S_RDWAIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_gs    = r_gs;
        n_ge    = r_ge;
        n_tgt   = r_tgt;
        n_stat  = r_stat;
        n_pend  = 1'b0;
        n_waddr = r_waddr;
        n_rd    = '0;
        w_fin   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_gs[AW-1:0];
        w_wdata = r_ch;
        w_re    = 1'b0;
        w_raddr = w_rd_phys[AW-1:0];
        unique case (r_state)
            S_EXEC: begin
                n_stat = ST_DONE;
                unique case (r_op)
                    OP_INSERT: begin
                        w_fin = 1'b1;
                        if (w_full) begin
                            n_stat = ST_FULL;
                        end else begin
                            w_we = 1'b1;
                            n_gs = w_gs_inc;
                        end
                    end
                    OP_BACKSPACE: begin
                        w_fin = 1'b1;
                        if (w_gs_zero) begin
                            n_stat = ST_IGNORED;
                        end else begin
                            n_gs = w_gs_dec;
                        end
                    end
                    OP_LEFT: begin
                        if (w_gs_zero) begin
                            n_stat = ST_IGNORED;
                            w_fin  = 1'b1;
                        end else begin
                            n_tgt = w_gs_dec;
                        end
                    end
                    OP_RIGHT: begin
                        if (w_ge_top) begin
                            n_stat = ST_IGNORED;
                            w_fin  = 1'b1;
                        end else begin
                            n_tgt = w_gs_inc;
                        end
                    end
                    OP_MOVE_TO: begin
                        if (w_pos_gt_len) begin
                            n_tgt  = w_len;
                            n_stat = ST_IGNORED;
                        end else begin
                            n_tgt = w_pos_x[PW-1:0];
                        end
                    end
                    OP_DELETE: begin
                        if (w_del_bad) begin
                            n_stat = ST_IGNORED;
                            w_fin  = 1'b1;
                        end else begin
                            n_tgt = w_pos_x[PW-1:0];
                        end
                    end
                    OP_READ: begin
                        if (w_rd_bad) begin
                            n_stat = ST_IGNORED;
                            w_fin  = 1'b1;
                        end else begin
                            w_re = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        n_gs  = '0;
                        n_ge  = CAP_P;
                        w_fin = 1'b1;
                    end
                    default: w_fin = 1'b1;
                endcase
            end
            S_WALK: begin
                // The byte read in the previous cycle lands on the far side of the gap.
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_waddr;
                    w_wdata = w_rdata;
                end
                if (!w_at_tgt) begin
                    w_re   = 1'b1;
                    n_pend = 1'b1;
                    if (r_gs > r_tgt) begin
                        w_raddr = w_gs_dec[AW-1:0];
                        n_waddr = w_ge_dec[AW-1:0];
                        n_gs    = w_gs_dec;
                        n_ge    = w_ge_dec;
                    end else begin
                        w_raddr = r_ge[AW-1:0];
                        n_waddr = r_gs[AW-1:0];
                        n_gs    = w_gs_inc;
                        n_ge    = w_ge_inc;
                    end
                end else if (r_op != OP_DELETE) begin
                    w_fin = 1'b1;
                end
            end
            S_DEL: begin
                n_ge  = r_ge + w_adv[PW-1:0];
                w_fin = 1'b1;
            end
            S_RDWAIT: begin
                n_rd  = w_rdata;
                w_fin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gs    <= '0;
            r_ge    <= CAP_P;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gs    <= n_gs;
            r_ge    <= n_ge;
            r_pend  <= n_pend;
            if (w_fin) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt   <= n_tgt;
        r_stat  <= n_stat;
        r_waddr <= n_waddr;
        if (w_accept) begin
            r_op   <= i_cmd.op;
            r_ch   <= i_cmd.char_in;
            r_pos  <= i_cmd.position;
            r_rend <= i_cmd.range_end;
        end
        if (w_fin) begin
            r_char_out <= n_rd;
            r_status   <= n_stat;
            r_cursor   <= POS_W'(n_gs);
            r_len      <= POS_W'(n_len);
        end
    end
endmodule

FILE: rtl/gbts_checker.sv
`include "assert_macros.svh"

module gbts_checker #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cmd_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [gbts_pkg::CHAR_W-1:0] i_rsp_char_out,
    input logic [1:0]                  i_rsp_status,
    input logic [gbts_pkg::POS_W-1:0]  i_rsp_cursor,
    input logic [gbts_pkg::POS_W-1:0]  i_rsp_text_length
);
    import gbts_pkg::*;

    localparam logic [POS_W-1:0] CAP_F  = POS_W'(CAPACITY);
    localparam logic             NARROW = (CAPACITY < 2048);
    localparam int               BEAT_W = 1 + CHAR_W + 2 + 2 * POS_W;

    logic              w_stall;
    logic [BEAT_W-1:0] w_beat;
    logic              w_full_beat;
    logic              w_len_cap;
    logic              w_chk_cur;
    logic              w_cur_ok;

    assign w_stall     = i_rsp_valid && !i_rsp_ready;
    assign w_beat      = {i_rsp_valid, i_rsp_char_out, i_rsp_status, i_rsp_cursor,
                          i_rsp_text_length};
    assign w_full_beat = i_rsp_valid && (i_rsp_status == ST_FULL);
    assign w_len_cap   = (i_rsp_text_length == CAP_F);
    assign w_chk_cur   = i_rsp_valid && NARROW;
    assign w_cur_ok    = (i_rsp_cursor <= i_rsp_text_length);

    `GBTS_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, w_stall, $stable(w_beat), "stalled beat changed")
    `GBTS_ASSERT_IMP(a_no_take, i_clk, i_rst_n, w_stall, !i_cmd_ready, "input taken while stalled")
    `GBTS_ASSERT_IMP(a_full_len, i_clk, i_rst_n, w_full_beat, w_len_cap, "full with spare room")
    `GBTS_ASSERT_IMP(a_cursor_in, i_clk, i_rst_n, w_chk_cur, w_cur_ok, "cursor past end of text")
endmodule

bind gap_buffer_text_store gbts_checker #(.CAPACITY(CAPACITY)) u_gbts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_ready       (i_cmd.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_char_out    (o_rsp.char_out),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_cursor      (o_rsp.cursor),
    .i_rsp_text_length (o_rsp.text_length)
);

FILE: tb/tb_top.sv
module tb_top;
    import gbts_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 40;
    localparam int PHASE_ITEMS  = 150;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    typedef struct {
        t_op              op;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  rend;
    } t_edit_cmd;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        t_status           st;
        logic [POS_W-1:0]  cur;
        logic [POS_W-1:0]  len;
    } t_edit_ans;

    typedef struct {
        t_edit_cmd c;
        bit        typed;
        t_edit_ans want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    gbts_cmd_if cmd_if ();
    gbts_rsp_if rsp_if ();

    gap_buffer_text_store #(
        .CAPACITY (CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Own copy of the store: text before the gap in [0, gap_lo), after it in [gap_hi, CAP).
    logic [CHAR_W-1:0] text_bytes [CAP];
    int unsigned       gap_lo;
    int unsigned       gap_hi;

    t_edit_ans   pending_answers [$];
    t_edit_ans   no_answer;
    int unsigned errors      = 0;
    int unsigned reports     = 0;
    int unsigned cycle_count = 0;
    int          snd_idle_pct;
    int          rcv_stall_pct;
    bit          hold_req    = 1'b0;
    logic        hold_rsp    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned stored_len();
        return CAP - (gap_hi - gap_lo);
    endfunction

    // Slides the gap one byte at a time until it starts at target.
    function automatic void move_gap(input int unsigned target);
        while (gap_lo > target && gap_lo != 0) begin
            text_bytes[gap_hi - 1] = text_bytes[gap_lo - 1];
            gap_lo--;
            gap_hi--;
        end
        while (gap_lo < target && gap_hi < CAP) begin
            text_bytes[gap_lo] = text_bytes[gap_hi];
            gap_lo++;
            gap_hi++;
        end
    endfunction

    function automatic t_edit_ans apply_edit(input t_edit_cmd c);
        t_edit_ans   a;
        int unsigned len;
        int unsigned pos;
        int unsigned cnt;
        len  = stored_len();
        pos  = c.pos;
        a.ch = '0;
        a.st = ST_DONE;
        case (c.op)
            OP_INSERT: begin
                if (gap_lo == gap_hi) begin
                    a.st = ST_FULL;
                end else begin
                    text_bytes[gap_lo] = c.ch;
                    gap_lo++;
                end
            end
            OP_BACKSPACE: begin
                if (gap_lo == 0) a.st = ST_IGNORED;
                else gap_lo--;
            end
            OP_LEFT: begin
                if (gap_lo == 0) a.st = ST_IGNORED;
                else move_gap(gap_lo - 1);
            end
            OP_RIGHT: begin
                if (gap_hi >= CAP) a.st = ST_IGNORED;
                else move_gap(gap_lo + 1);
            end
            OP_MOVE_TO: begin
                if (pos > len) begin
                    pos  = len;
                    a.st = ST_IGNORED;
                end
                move_gap(pos);
            end
            OP_DELETE: begin
                if (pos >= c.rend || pos > len) begin
                    a.st = ST_IGNORED;
                end else begin
                    move_gap(pos);
                    cnt = c.rend - pos;
                    // A range running past the text is cut at its end.
                    if (cnt > CAP - gap_hi) cnt = CAP - gap_hi;
                    gap_hi += cnt;
                end
            end
            OP_READ: begin
                if (pos >= len) a.st = ST_IGNORED;
                else if (pos < gap_lo) a.ch = text_bytes[pos];
                else a.ch = text_bytes[pos + (gap_hi - gap_lo)];
            end
            default: begin
                gap_lo = 0;
                gap_hi = CAP;
            end
        endcase
        a.cur = POS_W'(gap_lo);
        a.len = POS_W'(stored_len());
        return a;
    endfunction

    function automatic t_edit_cmd mk_cmd(input t_op op, input int ch, input int pos,
                                         input int rend);
        t_edit_cmd c;
        c.op   = op;
        c.ch   = CHAR_W'(ch);
        c.pos  = POS_W'(pos);
        c.rend = POS_W'(rend);
        return c;
    endfunction

    function automatic t_dir_row mk_row(input t_op op, input int ch, input int pos,
                                        input int rend, input bit typed, input int ch_x,
                                        input t_status st, input int cur, input int len);
        t_dir_row r;
        r.c        = mk_cmd(op, ch, pos, rend);
        r.typed    = typed;
        r.want.ch  = CHAR_W'(ch_x);
        r.want.st  = st;
        r.want.cur = POS_W'(cur);
        r.want.len = POS_W'(len);
        return r;
    endfunction

    // Mostly targets inside the text, now and then its ends or anywhere in the field.
    function automatic t_edit_cmd random_edit();
        int unsigned len;
        int unsigned w;
        int unsigned pick;
        int unsigned p;
        int unsigned r;
        t_op         op;
        len = stored_len();
        w   = $urandom_range(0, 99);
        if (w < 30) op = OP_INSERT;
        else if (w < 38) op = OP_BACKSPACE;
        else if (w < 46) op = OP_LEFT;
        else if (w < 54) op = OP_RIGHT;
        else if (w < 64) op = OP_MOVE_TO;
        else if (w < 73) op = OP_DELETE;
        else if (w < 99) op = OP_READ;
        else op = OP_CLEAR;
        pick = $urandom_range(0, 15);
        if (pick == 0) p = $urandom_range(0, POS_MAX);
        else if (pick == 1) p = len;
        else if (pick == 2) p = 0;
        else p = $urandom_range(0, len);
        if (op == OP_DELETE) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) r = $urandom_range(0, POS_MAX);
            else if (pick == 1) r = p;
            else r = p + $urandom_range(1, 6);
            if (r > POS_MAX) r = POS_MAX;
        end else begin
            r = $urandom_range(0, POS_MAX);
        end
        return mk_cmd(op, $urandom_range(0, 255), p, r);
    endfunction

    // Offers one command, waits until it is taken, then records what it should answer.
    task automatic send_edit(input t_edit_cmd c, input bit typed, input t_edit_ans want);
        t_edit_ans a;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.op        <= c.op;
        cmd_if.char_in   <= c.ch;
        cmd_if.position  <= c.pos;
        cmd_if.range_end <= c.rend;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        a = apply_edit(c);
        pending_answers.push_back(typed ? want : a);
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        errors++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : answer_check
        t_edit_ans want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_answers.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: result beat with nothing expected, got cursor %0d length %0d",
                             $time, rsp_if.cursor, rsp_if.text_length);
                end
            end else begin
                want = pending_answers.pop_front();
                if (rsp_if.char_out !== want.ch)
                    note_mismatch("char_out", want.ch, rsp_if.char_out);
                if (rsp_if.status !== want.st)
                    note_mismatch("status", want.st, rsp_if.status);
                if (rsp_if.cursor !== want.cur)
                    note_mismatch("cursor", want.cur, rsp_if.cursor);
                if (rsp_if.text_length !== want.len)
                    note_mismatch("text_length", want.len, rsp_if.text_length);
            end
        end
        rsp_if.ready <= !(hold_rsp || ($urandom_range(0, 99) < rcv_stall_pct));
    end

    // One long hold on the result side so that the block backs up and stalls commands.
    initial begin : rsp_hold_off
        wait (hold_req);
        @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL gap_buffer_text_store");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row steps [$];
        int       ph;
        int       n;
        i_rst_n          <= 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.op        <= OP_INSERT;
        cmd_if.char_in   <= '0;
        cmd_if.position  <= '0;
        cmd_if.range_end <= '0;
        rcv_stall_pct    <= 0;
        snd_idle_pct = 0;
        gap_lo       = 0;
        gap_hi       = CAP;

        // op, char_in, position, range_end, typed, then char_out, status, cursor, length
        steps.push_back(mk_row(OP_BACKSPACE, 8'h00, 0, 0, 1, 8'h00, ST_IGNORED, 0, 0));
        steps.push_back(mk_row(OP_LEFT, 8'h00, 0, 0, 1, 8'h00, ST_IGNORED, 0, 0));
        steps.push_back(mk_row(OP_RIGHT, 8'hFF, POS_MAX, POS_MAX, 1, 8'h00, ST_IGNORED, 0, 0));
        steps.push_back(mk_row(OP_READ, 8'h00, 0, 0, 1, 8'h00, ST_IGNORED, 0, 0));
        steps.push_back(mk_row(OP_MOVE_TO, 8'h00, POS_MAX, 0, 1, 8'h00, ST_IGNORED, 0, 0));
        steps.push_back(mk_row(OP_DELETE, 8'h00, 0, 0, 1, 8'h00, ST_IGNORED, 0, 0));
        steps.push_back(mk_row(OP_INSERT, 8'h00, 0, 0, 1, 8'h00, ST_DONE, 1, 1));
        steps.push_back(mk_row(OP_INSERT, 8'hFF, 0, 0, 1, 8'h00, ST_DONE, 2, 2));
        steps.push_back(mk_row(OP_INSERT, 8'hA5, 0, 0, 1, 8'h00, ST_DONE, 3, 3));
        steps.push_back(mk_row(OP_INSERT, 8'h5A, 0, 0, 1, 8'h00, ST_DONE, 4, 4));
        steps.push_back(mk_row(OP_READ, 8'h00, 0, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_READ, 8'h00, 1, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_LEFT, 8'h00, 0, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_LEFT, 8'h00, 0, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_READ, 8'h00, 3, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_RIGHT, 8'h00, 0, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_MOVE_TO, 8'h00, 0, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_READ, 8'h00, 2, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_MOVE_TO, 8'h00, 4, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_DELETE, 8'h00, 5, 7, 1, 8'h00, ST_IGNORED, 4, 4));
        steps.push_back(mk_row(OP_DELETE, 8'h00, 1, POS_MAX, 1, 8'h00, ST_DONE, 1, 1));
        steps.push_back(mk_row(OP_BACKSPACE, 8'h00, 0, 0, 1, 8'h00, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_INSERT, 8'h3C, 0, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_INSERT, 8'hC3, 0, 0, 0, 0, ST_DONE, 0, 0));
        steps.push_back(mk_row(OP_READ, 8'h00, 2, 0, 1, 8'h00, ST_IGNORED, 2, 2));
        steps.push_back(mk_row(OP_CLEAR, 8'h00, 0, 0, 1, 8'h00, ST_DONE, 0, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        snd_idle_pct   = 7;
        rcv_stall_pct <= 7;
        foreach (steps[i]) send_edit(steps[i].c, steps[i].typed, steps[i].want);

        // Fill the store to capacity, then work the edges of a full buffer.
        snd_idle_pct   = 0;
        rcv_stall_pct <= 0;
        while (stored_len() < CAP + 3) begin
            send_edit(mk_cmd(OP_INSERT, $urandom_range(0, 255), $urandom_range(0, POS_MAX),
                             $urandom_range(0, POS_MAX)), 0, no_answer);
            if (stored_len() == CAP) break;
        end
        repeat (3) send_edit(mk_cmd(OP_INSERT, $urandom_range(0, 255), 0, 0), 0, no_answer);
        send_edit(mk_cmd(OP_READ, 0, CAP - 1, 0), 0, no_answer);
        send_edit(mk_cmd(OP_READ, 0, CAP, 0), 0, no_answer);
        send_edit(mk_cmd(OP_MOVE_TO, 0, 0, 0), 0, no_answer);
        send_edit(mk_cmd(OP_LEFT, 0, 0, 0), 0, no_answer);
        send_edit(mk_cmd(OP_READ, 0, 0, 0), 0, no_answer);
        send_edit(mk_cmd(OP_MOVE_TO, 0, POS_MAX, 0), 0, no_answer);
        send_edit(mk_cmd(OP_RIGHT, 0, 0, 0), 0, no_answer);
        send_edit(mk_cmd(OP_INSERT, 8'h81, 0, 0), 0, no_answer);
        send_edit(mk_cmd(OP_DELETE, 0, 100, POS_MAX), 0, no_answer);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct   = 0;
                    rcv_stall_pct <= 0;
                    hold_req       = 1'b1;
                end
                1: begin
                    snd_idle_pct   = 87;
                    rcv_stall_pct <= 0;
                end
                2: begin
                    snd_idle_pct   = 0;
                    rcv_stall_pct <= 87;
                end
                default: begin
                    snd_idle_pct   = 7;
                    rcv_stall_pct <= 7;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) send_edit(random_edit(), 0, no_answer);
        end

        cmd_if.valid  <= 1'b0;
        rcv_stall_pct <= 0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS gap_buffer_text_store");
        end else begin
            $display("FAIL gap_buffer_text_store");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/gbts_pkg.sv
rtl/gbts_if.sv
rtl/gbts_ram.sv
rtl/gap_buffer_text_store.sv
rtl/gbts_checker.sv
tb/tb_top.sv
